// ===== design/tam_pkg.sv =====
// Shared types, constants and register codes of the throttle arming actuator mixer.
package tam_pkg;

	localparam int NUM_ACT = 6;
	localparam int EXCITE_CHANNELS = 3;
	localparam int SIGNAL_INPUTS = 3;
	localparam int EXC_LANES = (EXCITE_CHANNELS < SIGNAL_INPUTS) ? EXCITE_CHANNELS : SIGNAL_INPUTS;
	localparam int TGT_W = 3;
	localparam int THR_W = 15;
	localparam int CNT_W = 2;
	localparam int TGTS_W = TGT_W * SIGNAL_INPUTS;

	localparam logic [TGT_W-1:0] THR_IDX = 3'd5;

	localparam logic [THR_W-1:0] LOW_THR_RST = 15'd819;
	localparam logic [THR_W-1:0] HIGH_THR_RST = 15'd15565;
	localparam logic [CNT_W-1:0] CNT_RST = 2'd0;
	localparam logic [TGTS_W-1:0] TGTS_RST = 9'd511;

	localparam logic signed [16:0] SAT_HI = 17'sd16384;
	localparam logic signed [16:0] SAT_LO = -17'sd16384;
	localparam logic signed [16:0] SAT_ZERO = 17'sd0;

	typedef logic signed [15:0] q14_t;

	typedef enum logic [1:0] {
		CFG_LOW_THR = 2'd0,
		CFG_HIGH_THR = 2'd1,
		CFG_EXC_COUNT = 2'd2,
		CFG_EXC_TARGETS = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ARM_WAIT_LOW = 4'b0001,
		ARM_WAIT_HIGH = 4'b0010,
		ARM_WAIT_LOW2 = 4'b0100,
		ARM_DONE = 4'b1000
	} arm_state_t;

	typedef struct packed {
		logic step;
		logic sas;
		q14_t thr;
		logic [THR_W-1:0] lo;
		logic [THR_W-1:0] hi;
	} arm_ctl_t;

	typedef struct packed {
		logic latched_q;
		logic latched_next;
	} arm_sts_t;

endpackage

// ===== design/throttle_arming_actuator_mixer_top.sv =====
// Top level of the throttle arming actuator mixer with its handshake pipeline.
// An input beat passes one input register, then one result register, with the mixing, arming
// and safety logic between them.
// Throughput is one item per cycle while out_ready holds; the input register moves on whenever the result register
// is empty or is being read in the same cycle.
// Reset clears both valid flags, the arming sequence and the override latch, and loads the
// configuration registers with their default values.
module throttle_arming_actuator_mixer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [tam_pkg::THR_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                aileron_cmd,
	input  logic signed [15:0]                elevator_cmd,
	input  logic signed [15:0]                rudder_cmd,
	input  logic signed [15:0]                flaps_cmd,
	input  logic signed [15:0]                gear_cmd,
	input  logic signed [15:0]                throttle_cmd,
	input  logic                              excite_running,
	input  logic                              sas_mode,
	input  logic                              safety_zone,
	input  logic signed [15:0]                excite_signal_a,
	input  logic signed [15:0]                excite_signal_b,
	input  logic signed [15:0]                excite_signal_c,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [15:0]                aileron_out,
	output logic signed [15:0]                elevator_out,
	output logic signed [15:0]                rudder_out,
	output logic signed [15:0]                flaps_out,
	output logic signed [15:0]                gear_out,
	output logic signed [15:0]                throttle_out,
	output logic                              override_active
);

	logic [tam_pkg::THR_W-1:0] low_thr_q;
	logic [tam_pkg::THR_W-1:0] high_thr_q;
	logic [tam_pkg::CNT_W-1:0] exc_count_q;
	logic [tam_pkg::TGTS_W-1:0] exc_targets_q;

	logic valid_s1;
	logic valid_s2;
	logic adv;
	logic in_fire;

	tam_pkg::q14_t cmd_s1 [tam_pkg::NUM_ACT];
	tam_pkg::q14_t sig_s1 [tam_pkg::SIGNAL_INPUTS];
	logic run_s1;
	logic sas_s1;
	logic safety_s1;

	tam_pkg::q14_t act [tam_pkg::NUM_ACT];
	tam_pkg::q14_t act_s2 [tam_pkg::NUM_ACT];
	logic override_s2;

	tam_pkg::arm_ctl_t arm_ctl;
	tam_pkg::arm_sts_t arm_sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q <= tam_pkg::LOW_THR_RST;
			high_thr_q <= tam_pkg::HIGH_THR_RST;
			exc_count_q <= tam_pkg::CNT_RST;
			exc_targets_q <= tam_pkg::TGTS_RST;
		end else if (cfg_valid) begin
			case (tam_pkg::cfg_idx_t'(cfg_index))
				tam_pkg::CFG_LOW_THR: low_thr_q <= cfg_data;
				tam_pkg::CFG_HIGH_THR: high_thr_q <= cfg_data;
				tam_pkg::CFG_EXC_COUNT: exc_count_q <= cfg_data[tam_pkg::CNT_W-1:0];
				tam_pkg::CFG_EXC_TARGETS: exc_targets_q <= cfg_data[tam_pkg::TGTS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1[0] <= aileron_cmd;
			cmd_s1[1] <= elevator_cmd;
			cmd_s1[2] <= rudder_cmd;
			cmd_s1[3] <= flaps_cmd;
			cmd_s1[4] <= gear_cmd;
			cmd_s1[5] <= throttle_cmd;
			sig_s1[0] <= excite_signal_a;
			sig_s1[1] <= excite_signal_b;
			sig_s1[2] <= excite_signal_c;
			run_s1 <= excite_running;
			sas_s1 <= sas_mode;
			safety_s1 <= safety_zone;
		end
	end

	tam_mix u_mix (
		.run     (run_s1),
		.count   (exc_count_q),
		.targets (exc_targets_q),
		.cmd     (cmd_s1),
		.sig     (sig_s1),
		.act     (act)
	);

	assign arm_ctl.step = adv;
	assign arm_ctl.sas = sas_s1;
	assign arm_ctl.thr = cmd_s1[5];
	assign arm_ctl.lo = low_thr_q;
	assign arm_ctl.hi = high_thr_q;

	tam_arm u_arm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (arm_ctl),
		.sts    (arm_sts)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < tam_pkg::NUM_ACT - 1; k++) begin
				act_s2[k] <= act[k];
			end
			act_s2[5] <= (!arm_sts.latched_next && safety_s1) ? '0 : act[5];
			override_s2 <= arm_sts.latched_next;
		end
	end

	assign out_valid = valid_s2;
	assign aileron_out = act_s2[0];
	assign elevator_out = act_s2[1];
	assign rudder_out = act_s2[2];
	assign flaps_out = act_s2[3];
	assign gear_out = act_s2[4];
	assign throttle_out = act_s2[5];
	assign override_active = override_s2;

	// Once latched, the override can only be cleared by reset.
	a_latch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(arm_sts.latched_q))
		else $error("override latch fell");

	// An empty input register always takes a new beat.
	a_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty input register");

	// A beat moved out of the input register shows up as a result.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced beat lost");

	// A result beat shown with override set stays consistent with the latch.
	a_override_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && override_active) |-> arm_sts.latched_q)
		else $error("override shown without latch");

endmodule

// ===== design/tam_mix.sv =====
// Excitation mixer that adds channel signals to their target actuators with saturation.
module tam_mix (
	input  logic                          run,
	input  logic [tam_pkg::CNT_W-1:0]     count,
	input  logic [tam_pkg::TGTS_W-1:0]    targets,
	input  tam_pkg::q14_t                 cmd [tam_pkg::NUM_ACT],
	input  tam_pkg::q14_t                 sig [tam_pkg::SIGNAL_INPUTS],
	output tam_pkg::q14_t                 act [tam_pkg::NUM_ACT]
);

	logic [tam_pkg::TGT_W-1:0] tgt;
	logic signed [16:0] sum;
	logic signed [16:0] floor_v;

	always_comb begin
		act = cmd;
		tgt = '0;
		sum = '0;
		floor_v = tam_pkg::SAT_LO;
		if (run) begin
			for (int i = 0; i < tam_pkg::EXC_LANES; i++) begin
				tgt = targets[tam_pkg::TGT_W*i +: tam_pkg::TGT_W];
				if ((i < int'(count)) && (int'(tgt) < tam_pkg::NUM_ACT)) begin
					sum = {act[tgt][15], act[tgt]} + {sig[i][15], sig[i]};
					floor_v = (tgt == tam_pkg::THR_IDX) ? tam_pkg::SAT_ZERO : tam_pkg::SAT_LO;
					if (sum < floor_v) begin
						sum = floor_v;
					end
					if (sum > tam_pkg::SAT_HI) begin
						sum = tam_pkg::SAT_HI;
					end
					act[tgt] = sum[15:0];
				end
			end
		end
	end

endmodule

// ===== design/tam_arm.sv =====
// Throttle arming sequencer that latches the permanent throttle override.
module tam_arm (
	input  logic              clk,
	input  logic              arst_n,
	input  tam_pkg::arm_ctl_t ctl,
	output tam_pkg::arm_sts_t sts
);

	tam_pkg::arm_state_t state_q;
	tam_pkg::arm_state_t state_d;
	logic thr_low;
	logic thr_high;

	assign thr_low = ctl.thr < $signed({1'b0, ctl.lo});
	assign thr_high = ctl.thr > $signed({1'b0, ctl.hi});

	always_comb begin
		state_d = state_q;
		if (ctl.step && ctl.sas) begin
			case (state_q)
				tam_pkg::ARM_WAIT_LOW: begin
					if (thr_low) begin
						state_d = tam_pkg::ARM_WAIT_HIGH;
					end
				end
				tam_pkg::ARM_WAIT_HIGH: begin
					if (thr_high) begin
						state_d = tam_pkg::ARM_WAIT_LOW2;
					end
				end
				tam_pkg::ARM_WAIT_LOW2: begin
					if (thr_low) begin
						state_d = tam_pkg::ARM_DONE;
					end
				end
				tam_pkg::ARM_DONE: begin
					state_d = tam_pkg::ARM_DONE;
				end
				default: begin
					state_d = tam_pkg::ARM_WAIT_LOW;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tam_pkg::ARM_WAIT_LOW;
		end else begin
			state_q <= state_d;
		end
	end

	assign sts.latched_q = (state_q == tam_pkg::ARM_DONE);
	assign sts.latched_next = (state_d == tam_pkg::ARM_DONE);

endmodule
